@@ hdl/jac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_pkg
// Shared widths, result type and symbol codes for the Jacobi symbol block.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = $clog2(OPERAND_BITS + 1);

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic signed [1:0]       t_symbol;

    localparam t_symbol SYM_POS  = 2'sb01;
    localparam t_symbol SYM_ZERO = 2'sb00;
    localparam t_symbol SYM_NEG  = 2'sb11;

    // status from the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

@@ hdl/jac_remainder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_remainder
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module jac_remainder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  jac_pkg::t_operand   i_dividend,
    input  jac_pkg::t_operand   i_divisor,   // held stable while busy
    output jac_pkg::t_rem_stat  o_stat,
    output jac_pkg::t_operand   o_remainder
);

    localparam int W = jac_pkg::OPERAND_BITS;

    logic                      r_busy;
    logic                      r_done;
    logic [jac_pkg::CNT_W-1:0] r_cnt;
    jac_pkg::t_operand         r_x;     // dividend shift register
    jac_pkg::t_operand         r_rem;

    logic [W:0] rem_sh;
    logic [W:0] diff;
    logic       ge;

    assign rem_sh = {r_rem, r_x[W-1]};
    assign diff   = rem_sh - {1'b0, i_divisor};
    assign ge     = (rem_sh >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= W[jac_pkg::CNT_W-1:0];
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[W-2:0], 1'b0};
            r_rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

@@ hdl/jacobi_symbol.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_symbol
// Iterative Jacobi symbol (d/n) evaluator, result -1, 0 or +1.
// ----------------------------------------------------------------------------
// A round ending on a zero remainder ends the evaluation; a modulus of 0 or 1
//   goes from the check straight to the result.
// Throughput: one word at a time, set by the bit-serial remainder (one bit per
//   cycle, up to about OPERAND_BITS rounds); busy drops in the result's cycle.
// Reset (synchronous, active low) returns to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module jacobi_symbol (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [jac_pkg::OPERAND_BITS-1:0] i_top_value,
    input  logic [jac_pkg::OPERAND_BITS-1:0] i_modulus,
    output logic                      busy,
    output logic                      o_valid,
    output logic signed [1:0]         o_symbol
);

    // Round structure:
    //   CHECK : y > 1 ? kick off x mod y : deliver sign
    //   DIV   : wait for the serial remainder
    //   FOLD  : x > y/2 -> x = y - x (flip if y = 3 mod 4); zero -> symbol 0
    //   STRIP : shift out factors of four, one per cycle, then one factor
    //           of two (flip if y = 3,5 mod 8), reciprocity flip, swap
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FOLD,
        S_STRIP
    } t_state;

    t_state              r_state;
    jac_pkg::t_operand   r_x;
    jac_pkg::t_operand   r_y;
    logic                r_neg;      // running sign is -1
    logic                r_valid;
    jac_pkg::t_symbol    r_symbol;

    logic                rem_start;
    jac_pkg::t_rem_stat  rem_stat;
    jac_pkg::t_operand   rem_val;

    // state-dependent helpers
    logic                y_gt1;
    logic                fold;
    jac_pkg::t_operand   x_half;     // x after dropping a single factor of two
    logic                flip_two;
    logic                flip_recip;

    assign y_gt1     = (r_y > jac_pkg::t_operand'(1));
    assign rem_start = (r_state == S_CHECK) && y_gt1;
    assign fold      = (r_x > (r_y >> 1));

    assign x_half    = r_x[0] ? r_x : (r_x >> 1);
    assign flip_two  = !r_x[0] && ((r_y[2:0] == 3'd3) || (r_y[2:0] == 3'd5));
    assign flip_recip = (x_half[1:0] == 2'd3) && (r_y[1:0] == 2'd3);

    jac_remainder u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rem_start),
        .i_dividend  (r_x),
        .i_divisor   (r_y),
        .o_stat      (rem_stat),
        .o_remainder (rem_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_neg    <= 1'b0;
            r_symbol <= jac_pkg::SYM_POS;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x     <= i_top_value;
                        r_y     <= i_modulus;
                        r_neg   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (y_gt1) begin
                        r_state <= S_DIV;
                    end else begin
                        r_valid  <= 1'b1;
                        r_symbol <= r_neg ? jac_pkg::SYM_NEG : jac_pkg::SYM_POS;
                        r_state  <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        r_x     <= rem_val;
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_x == '0) begin
                        // remainder zero: gcd > 1
                        r_valid  <= 1'b1;
                        r_symbol <= jac_pkg::SYM_ZERO;
                        r_state  <= S_IDLE;
                    end else begin
                        if (fold) begin
                            r_x <= r_y - r_x;
                            if (r_y[1:0] == 2'd3) begin
                                r_neg <= !r_neg;
                            end
                        end
                        r_state <= S_STRIP;
                    end
                end
                S_STRIP: begin
                    if (r_x[1:0] == 2'd0) begin
                        r_x <= r_x >> 2;
                    end else begin
                        r_neg   <= r_neg ^ flip_two ^ flip_recip;
                        r_x     <= r_y;
                        r_y     <= x_half;
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a result always coincides with the return to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // the divisor is never 0 or 1 while the remainder unit runs
    a_div_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rem_stat.busy || rem_stat.done) |-> y_gt1)
        else $error("remainder unit running with divisor below 2");

    // a finished remainder is reduced below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (rem_val < r_y) && (r_state == S_DIV))
        else $error("remainder out of range or unexpected");

    // stripping only sees a nonzero value, so it always ends
    a_strip_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STRIP) |-> (r_x != '0))
        else $error("strip entered with zero value");

endmodule
